### design/bpru_pkg.sv
// Package for the binary point record unpacker: types, codes and conversion helpers.
`timescale 1ns / 1ps
package bpru_pkg;

	localparam int MAX_RECORD_BYTES = 256;
	localparam int POS_W = $clog2(MAX_RECORD_BYTES);
	localparam int LEN_W = POS_W + 1;

	// Configuration register indexes
	localparam logic [2:0] REG_RECORD_BYTES = 3'd0;
	localparam logic [2:0] REG_X_OFFSET     = 3'd1;
	localparam logic [2:0] REG_Y_OFFSET     = 3'd2;
	localparam logic [2:0] REG_Z_OFFSET     = 3'd3;
	localparam logic [2:0] REG_X_FORMAT     = 3'd4;
	localparam logic [2:0] REG_Y_FORMAT     = 3'd5;
	localparam logic [2:0] REG_Z_FORMAT     = 3'd6;
	localparam logic [2:0] REG_POINT_COUNT  = 3'd7;

	// Field format codes
	localparam logic [2:0] FMT_I8  = 3'd0;
	localparam logic [2:0] FMT_I16 = 3'd1;
	localparam logic [2:0] FMT_I32 = 3'd2;
	localparam logic [2:0] FMT_U8  = 3'd3;
	localparam logic [2:0] FMT_U16 = 3'd4;
	localparam logic [2:0] FMT_U32 = 3'd5;
	localparam logic [2:0] FMT_F32 = 3'd6;
	localparam logic [2:0] FMT_NONE = 3'd7;

	localparam logic [10:0] EBASE_INT = 11'd1054;
	localparam logic [10:0] EBASE_SUB = 11'd905;
	localparam logic [10:0] EBIAS_F32 = 11'd896;

	// One completed record as passed from front to back
	typedef struct packed {
		logic [31:0] x_cap;
		logic [31:0] y_cap;
		logic [31:0] z_cap;
		logic [2:0]  x_fmt;
		logic [2:0]  y_fmt;
		logic [2:0]  z_fmt;
		logic        last;
	} rec_t;

	// One field after classification, before normalisation
	typedef struct packed {
		logic        use_norm;
		logic        sign;
		logic [31:0] mag;
		logic [4:0]  lz;
		logic [10:0] ebase;
		logic [63:0] direct;
	} fld_t;

	function automatic logic [2:0] field_size(input logic [2:0] fmt);
		logic [2:0] s;
		unique case (fmt)
			FMT_I8, FMT_U8:                    s = 3'd1;
			FMT_I16, FMT_U16:                  s = 3'd2;
			FMT_I32, FMT_U32, FMT_F32:         s = 3'd4;
			default:                           s = 3'd0;
		endcase
		return s;
	endfunction

	// Leading-zero count of a non-zero word; zero gives 31
	function automatic logic [4:0] lzc32(input logic [31:0] v);
		logic [4:0] r;
		r = 5'd31;
		for (int i = 0; i < 32; i++) begin
			if (v[i]) r = 5'(31 - i);
		end
		return r;
	endfunction

	// Classify one captured field
	function automatic fld_t prep(input logic [31:0] cap, input logic [2:0] fmt);
		fld_t f;
		logic signed [31:0] sv;
		logic [7:0] e;
		logic [22:0] m;
		f = '0;
		sv = '0;
		e = cap[30:23];
		m = cap[22:0];
		unique case (fmt)
			FMT_I8, FMT_I16, FMT_I32: begin
				if (fmt == FMT_I8) sv = 32'(signed'(cap[7:0]));
				else if (fmt == FMT_I16) sv = 32'(signed'(cap[15:0]));
				else sv = signed'(cap);
				f.sign = sv[31];
				f.mag = sv[31] ? 32'(-sv) : 32'(sv);
				f.use_norm = (f.mag != '0);
				f.ebase = EBASE_INT;
			end
			FMT_U8, FMT_U16, FMT_U32: begin
				if (fmt == FMT_U8) f.mag = {24'd0, cap[7:0]};
				else if (fmt == FMT_U16) f.mag = {16'd0, cap[15:0]};
				else f.mag = cap;
				f.use_norm = (f.mag != '0);
				f.ebase = EBASE_INT;
			end
			FMT_F32: begin
				f.sign = cap[31];
				f.ebase = EBASE_SUB;
				f.mag = {9'd0, m};
				if (e == 8'hFF) begin
					f.direct = {cap[31], 11'h7FF, (m != '0) ? (m | 23'h400000) : m, 29'd0};
				end else if (e == 8'd0) begin
					f.use_norm = (m != '0);
					f.direct = {cap[31], 63'd0};
				end else begin
					f.direct = {cap[31], 11'({3'd0, e}) + EBIAS_F32, m, 29'd0};
				end
			end
			default: f = '0;
		endcase
		f.lz = lzc32(f.mag);
		return f;
	endfunction

	// Finish one field: normalising shift and exponent
	function automatic logic [63:0] finish(input fld_t f);
		logic [31:0] sh;
		sh = f.mag << f.lz;
		if (f.use_norm) return {f.sign, f.ebase - 11'(f.lz), sh[30:0], 21'd0};
		return f.direct;
	endfunction

endpackage

### design/bpru_front.sv
// Front end: configuration registers, byte position tracking and field capture.
`timescale 1ns / 1ps
module bpru_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        data_byte,
	output logic              push,
	output bpru_pkg::rec_t    push_rec,
	input  logic              q_full
);
	import bpru_pkg::*;

	logic [8:0]       record_bytes_q;
	logic [7:0]       x_offset_q, y_offset_q, z_offset_q;
	logic [2:0]       x_format_q, y_format_q, z_format_q;
	logic [31:0]      point_count_q;
	logic [POS_W-1:0] pos_q;
	logic [31:0]      x_cap_q, y_cap_q, z_cap_q;
	logic [31:0]      done_q;
	logic             all_done_q;

	logic [LEN_W-1:0] len;
	logic             active, take, rec_end, last;
	logic [31:0]      x_nx, y_nx, z_nx, done_nx;

	// A field byte is merged into its capture word when the position falls in it
	function automatic logic [31:0] grab(input logic [31:0] cap, input logic [7:0] off,
			input logic [2:0] fmt, input logic [POS_W-1:0] pos, input logic [7:0] b);
		logic [31:0] c;
		logic [POS_W-1:0] d;
		c = cap;
		d = pos - POS_W'(off);
		if ({1'b0, pos} >= (POS_W+1)'(off) && {1'b0, d} < (POS_W+1)'(field_size(fmt)))
			c = c | (32'(b) << {d[1:0], 3'b000});
		return c;
	endfunction

	// Effective record length, clamped to the supported range
	always_comb begin
		if (record_bytes_q == '0) len = LEN_W'(1);
		else if (32'(record_bytes_q) > MAX_RECORD_BYTES) len = LEN_W'(MAX_RECORD_BYTES);
		else len = LEN_W'(record_bytes_q);
	end

	assign in_stall = q_full;
	assign take     = in_valid && !in_stall;
	assign active   = !all_done_q && point_count_q != '0 && done_q < point_count_q;
	assign rec_end  = (LEN_W'(pos_q) + LEN_W'(1)) >= len;
	assign done_nx  = done_q + 32'd1;
	assign last     = done_nx == point_count_q;

	// Captures restart with the first byte of every record
	always_comb begin
		x_nx = grab((pos_q == '0) ? '0 : x_cap_q, x_offset_q, x_format_q, pos_q, data_byte);
		y_nx = grab((pos_q == '0) ? '0 : y_cap_q, y_offset_q, y_format_q, pos_q, data_byte);
		z_nx = grab((pos_q == '0) ? '0 : z_cap_q, z_offset_q, z_format_q, pos_q, data_byte);
	end

	assign push = take && active && rec_end;
	always_comb begin
		push_rec.x_cap = x_nx;
		push_rec.y_cap = y_nx;
		push_rec.z_cap = z_nx;
		push_rec.x_fmt = x_format_q;
		push_rec.y_fmt = y_format_q;
		push_rec.z_fmt = z_format_q;
		push_rec.last  = last;
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_bytes_q <= 9'd12;
			x_offset_q <= 8'd0;
			y_offset_q <= 8'd4;
			z_offset_q <= 8'd8;
			x_format_q <= FMT_F32;
			y_format_q <= FMT_F32;
			z_format_q <= FMT_F32;
			point_count_q <= 32'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RECORD_BYTES: record_bytes_q <= cfg_data[8:0];
				REG_X_OFFSET:     x_offset_q <= cfg_data[7:0];
				REG_Y_OFFSET:     y_offset_q <= cfg_data[7:0];
				REG_Z_OFFSET:     z_offset_q <= cfg_data[7:0];
				REG_X_FORMAT:     x_format_q <= cfg_data[2:0];
				REG_Y_FORMAT:     y_format_q <= cfg_data[2:0];
				REG_Z_FORMAT:     z_format_q <= cfg_data[2:0];
				REG_POINT_COUNT:  point_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Record position and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			x_cap_q <= '0;
			y_cap_q <= '0;
			z_cap_q <= '0;
			done_q <= '0;
			all_done_q <= 1'b0;
		end else if (take && active) begin
			x_cap_q <= x_nx;
			y_cap_q <= y_nx;
			z_cap_q <= z_nx;
			if (rec_end) begin
				pos_q <= '0;
				done_q <= done_nx;
				if (last) all_done_q <= 1'b1;
			end else begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

endmodule

### design/bpru_queue.sv
// Two-entry queue of completed records between the front and back ends.
`timescale 1ns / 1ps
module bpru_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bpru_pkg::rec_t push_rec,
	output logic           full,
	input  logic           pop,
	output logic           q_valid,
	output bpru_pkg::rec_t head
);
	import bpru_pkg::*;

	rec_t       ent_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full    = cnt_q == 2'd2;
	assign q_valid = cnt_q != 2'd0;
	assign head    = ent_q[rd_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= push_rec;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

### design/bpru_back.sv
// Back end: two-stage conversion of captured fields to double bit patterns.
`timescale 1ns / 1ps
module bpru_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  bpru_pkg::rec_t head,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [63:0]    x_bits,
	output logic [63:0]    y_bits,
	output logic [63:0]    z_bits,
	output logic           last_point
);
	import bpru_pkg::*;

	fld_t x_s1, y_s1, z_s1;
	logic last_s1, valid_s1;
	logic out_free, take_s1;

	assign out_free = !out_valid || !out_stall;
	assign take_s1  = !valid_s1 || out_free;
	assign pop      = q_valid && take_s1;

	// Stage one: classification and leading-zero count
	always_ff @(posedge clk) begin
		if (pop) begin
			x_s1 <= prep(head.x_cap, head.x_fmt);
			y_s1 <= prep(head.y_cap, head.y_fmt);
			z_s1 <= prep(head.z_cap, head.z_fmt);
			last_s1 <= head.last;
		end
	end

	// Stage two: normalising shift into the output register
	always_ff @(posedge clk) begin
		if (valid_s1 && out_free) begin
			x_bits <= finish(x_s1);
			y_bits <= finish(y_s1);
			z_bits <= finish(z_s1);
			last_point <= last_s1;
		end
	end

	// Stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (take_s1) valid_s1 <= q_valid;
			if (out_free) out_valid <= valid_s1;
		end
	end

endmodule

### design/binary_point_record_unpacker.sv
// Top level of the binary point record unpacker.
// Usage:
// Bytes of the binary data section enter on data_byte with in_valid; a byte
// transfers at a clock edge where in_valid is high and in_stall is low.
// One point per complete record leaves on x_bits, y_bits, z_bits and
// last_point with out_valid, transferring where out_stall is low.
// Configuration is written through cfg_we, cfg_index and cfg_data while idle.
// Throughput is one byte per cycle while in_stall is low; the record counter
// and capture logic in the front end take a byte each cycle unless stalled.
// From the transfer of a record's final byte, the record enters the queue at
// that edge, then passes the classification stage and the normalising shift
// stage into the output register, which raises out_valid.
// When the receiver stalls, the output register holds, the pipeline fills and
// the two-entry queue absorbs records; in_stall rises only when it is full.
// Reset restores the default configuration and clears position, counters and
// all pipeline flags at once. After the last record further bytes are
// transferred and dropped until reset.
`timescale 1ns / 1ps
module binary_point_record_unpacker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] x_bits,
	output logic [63:0] y_bits,
	output logic [63:0] z_bits,
	output logic        last_point
);
	import bpru_pkg::*;

	logic push, full, pop, q_valid;
	rec_t push_rec, head;

	bpru_front u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte),
		.push(push), .push_rec(push_rec), .q_full(full)
	);

	bpru_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_rec(push_rec), .full(full),
		.pop(pop), .q_valid(q_valid), .head(head)
	);

	bpru_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .head(head), .pop(pop),
		.out_valid(out_valid), .out_stall(out_stall),
		.x_bits(x_bits), .y_bits(y_bits), .z_bits(z_bits), .last_point(last_point)
	);

endmodule
